### hw/rtl/lfa_pkg.sv
package lfa_pkg;

  localparam int SLOT_BITS_DEF   = 10;
  localparam int GROUP_BITS_DEF  = 5;
  localparam int GEN_SHIFT_DEF   = 24;
  localparam int VALUE_WIDTH_DEF = 64;

  localparam int ACT_W = 2;
  localparam int ID_W  = 32;
  localparam int GEN_W = 8;

  localparam logic [ACT_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FIND   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  // control from the sequencer to the used-bitmap store
  typedef struct packed {
    logic rd;
    logic wr;
  } map_ctl_t;

  typedef struct packed {
    logic busy;
    logic any_free;
  } map_sts_t;

  // a group never reaches past the last slot: a partial group acts as a smaller one
  function automatic int lfa_eff_bits(int slot_bits, int group_bits);
    return (group_bits < slot_bits) ? group_bits : slot_bits;
  endfunction

  function automatic int lfa_gidx_w(int slot_bits, int group_bits);
    return (slot_bits > group_bits) ? slot_bits - group_bits : 1;
  endfunction

endpackage

### hw/rtl/lfa_if.sv
interface lfa_req_if import lfa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [ACT_W-1:0]       action;
  logic [ID_W-1:0]        id;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, action, id, value, input ready);
  modport sink   (input valid, action, id, value, output ready);
endinterface

interface lfa_rsp_if import lfa_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [ID_W-1:0]        new_id;
  logic [VALUE_WIDTH-1:0] found_value;
  logic                   status;

  modport source (output valid, new_id, found_value, status, input ready);
  modport sink   (input valid, new_id, found_value, status, output ready);
endinterface

### hw/rtl/lfa_used_map.sv
module lfa_used_map import lfa_pkg::*; #(
  parameter int SLOT_BITS  = SLOT_BITS_DEF,
  parameter int GROUP_BITS = GROUP_BITS_DEF,
  localparam int EFF_BITS  = lfa_eff_bits(SLOT_BITS, GROUP_BITS),
  localparam int GSIZE     = 1 << EFF_BITS,
  localparam int NGRP      = 1 << (SLOT_BITS - EFF_BITS),
  localparam int GIDX_W    = lfa_gidx_w(SLOT_BITS, GROUP_BITS)
) (
  input  logic              clk,
  input  logic              rst,
  input  map_ctl_t          ctl,
  input  logic [GIDX_W-1:0] addr,
  input  logic [GSIZE-1:0]  wr_word,
  output logic [GSIZE-1:0]  rd_word,
  output logic [GIDX_W-1:0] free_grp,
  output map_sts_t          sts
);

  logic [GSIZE-1:0]  used_mem [NGRP];
  logic [NGRP-1:0]   group_full;
  logic              clr_busy;
  logic [GIDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy   <= 1'b1;
      clr_idx    <= '0;
      group_full <= '0;
    end else begin
      if (clr_busy) begin
        clr_idx <= clr_idx + GIDX_W'(1);
        if (clr_idx == GIDX_W'(NGRP - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      // a written word is full only when every slot of the group is taken
      if (ctl.wr) begin
        group_full[addr] <= &wr_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      used_mem[clr_idx] <= '0;
    end else if (ctl.wr) begin
      used_mem[addr] <= wr_word;
    end
    if (ctl.rd) begin
      rd_word <= used_mem[addr];
    end
  end

  // lowest group that still has a free slot
  always_comb begin
    free_grp = '0;
    for (int i = NGRP - 1; i >= 0; i--) begin
      if (!group_full[i]) begin
        free_grp = GIDX_W'(i);
      end
    end
  end

  assign sts.busy     = clr_busy;
  assign sts.any_free = ~&group_full;

endmodule

### hw/rtl/lowest_free_id_allocator.sv
// allocate: group word read at the transfer, then id add (S_ADD) and all-ones fixup (S_FIX),
//   result registered; find and remove: result from S_LOOK, registered likewise
// failed allocate and unknown action: result registered at transfer, 1 per cycle while rsp.ready
// one item in flight; the shared 32-bit adder and the one-port group-word store set the pace
// rst is synchronous; afterwards the used-bitmap store is swept one group per cycle,
//   2^(SLOT_BITS - min(GROUP_BITS, SLOT_BITS)) groups (32 by default), before the first transfer
module lowest_free_id_allocator import lfa_pkg::*; #(
  parameter int SLOT_BITS   = SLOT_BITS_DEF,
  parameter int GROUP_BITS  = GROUP_BITS_DEF,
  parameter int GEN_SHIFT   = GEN_SHIFT_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lfa_req_if.sink   req,
  lfa_rsp_if.source rsp
);

  localparam int EFF_BITS = lfa_eff_bits(SLOT_BITS, GROUP_BITS);
  localparam int GSIZE    = 1 << EFF_BITS;
  localparam int NSLOTS   = 1 << SLOT_BITS;
  localparam int GIDX_W   = lfa_gidx_w(SLOT_BITS, GROUP_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_FIX   = 3'd3;
  localparam logic [2:0] S_LOOK  = 3'd4;
  localparam logic [2:0] S_PUSH  = 3'd5;

  logic [2:0]             state;
  logic [ACT_W-1:0]       act;
  logic [SLOT_BITS-1:0]   slot_r;
  logic [GIDX_W-1:0]      grp_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [VALUE_WIDTH-1:0] v_rd;
  logic [GEN_W-1:0]       gen;
  logic [ID_W-1:0]        acc;
  logic [VALUE_WIDTH-1:0] value_mem [NSLOTS];

  logic                   out_valid;
  logic [ID_W-1:0]        hold_id;
  logic [VALUE_WIDTH-1:0] hold_found;
  logic                   hold_status;

  map_ctl_t               map_ctl;
  map_sts_t               map_sts;
  logic [GIDX_W-1:0]      map_addr;
  logic [GIDX_W-1:0]      free_grp;
  logic [GSIZE-1:0]       map_word;
  logic [GSIZE-1:0]       wr_word;

  logic                   accept;
  logic [SLOT_BITS-1:0]   in_slot;
  logic [GIDX_W-1:0]      in_grp;
  logic [EFF_BITS-1:0]    zero_pos;
  logic [EFF_BITS-1:0]    bit_sel;
  logic [SLOT_BITS-1:0]   new_slot;
  logic [ID_W-1:0]        add_a;
  logic [ID_W-1:0]        add_b;
  logic [ID_W-1:0]        add_sum;

  logic                   fin;
  logic [ID_W-1:0]        fin_id;
  logic [VALUE_WIDTH-1:0] fin_found;
  logic                   fin_status;
  logic                   out_free;

  lfa_used_map #(
    .SLOT_BITS  (SLOT_BITS),
    .GROUP_BITS (GROUP_BITS)
  ) u_map (
    .clk      (clk),
    .rst      (rst),
    .ctl      (map_ctl),
    .addr     (map_addr),
    .wr_word  (wr_word),
    .rd_word  (map_word),
    .free_grp (free_grp),
    .sts      (map_sts)
  );

  assign req.ready = (state == S_IDLE) && !map_sts.busy;
  assign accept    = req.valid && req.ready;
  assign in_slot   = req.id[SLOT_BITS-1:0];
  assign in_grp    = GIDX_W'(in_slot >> EFF_BITS);
  assign out_free  = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;

  always_comb begin
    if (state == S_IDLE) begin
      map_addr = (req.action == ACT_ALLOC) ? free_grp : in_grp;
    end else begin
      map_addr = grp_r;
    end
  end

  assign map_ctl.rd = accept;
  assign map_ctl.wr = (state == S_ALLOC) || ((state == S_LOOK) && (act == ACT_REMOVE));

  // lowest free slot in the group word
  always_comb begin
    zero_pos = '0;
    for (int i = GSIZE - 1; i >= 0; i--) begin
      if (!map_word[i]) begin
        zero_pos = EFF_BITS'(i);
      end
    end
  end

  assign bit_sel  = slot_r[EFF_BITS-1:0];
  assign new_slot = SLOT_BITS'({grp_r, zero_pos});
  assign wr_word  = (state == S_ALLOC) ? (map_word | (GSIZE'(1) << zero_pos))
                                       : (map_word & ~(GSIZE'(1) << bit_sel));

  // shared adder: slot plus shifted generation, then the all-ones skip
  always_comb begin
    if (state == S_ADD) begin
      add_a = ID_W'(slot_r);
      add_b = ID_W'(gen) << GEN_SHIFT;
    end else begin
      add_a = acc;
      add_b = (acc == '1) ? (ID_W'(1) << GEN_SHIFT) : '0;
    end
  end

  assign add_sum = add_a + add_b;

  always_comb begin
    fin        = 1'b0;
    fin_id     = '0;
    fin_found  = '0;
    fin_status = ST_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.action == ACT_ALLOC) begin
            if (!map_sts.any_free) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end
          end else if ((req.action != ACT_FIND) && (req.action != ACT_REMOVE)) begin
            fin = 1'b1;
          end
        end
      end
      S_FIX: begin
        fin    = 1'b1;
        fin_id = add_sum;
      end
      S_LOOK: begin
        fin = 1'b1;
        if ((act == ACT_FIND) && map_word[bit_sel]) begin
          fin_found = v_rd;
        end
      end
      S_PUSH: begin
        fin        = 1'b1;
        fin_id     = hold_id;
        fin_found  = hold_found;
        fin_status = hold_status;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      gen       <= '0;
    end else begin
      if (fin) begin
        state <= out_free ? S_IDLE : S_PUSH;
      end else begin
        case (state)
          S_IDLE: begin
            if (accept) begin
              state <= (req.action == ACT_ALLOC) ? S_ALLOC : S_LOOK;
            end
          end
          S_ALLOC: begin
            state <= S_ADD;
            gen   <= gen + GEN_W'(1);
          end
          S_ADD: begin
            state <= S_FIX;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
      if (fin && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act    <= req.action;
      slot_r <= in_slot;
      grp_r  <= map_addr;
      val_r  <= req.value;
    end
    if (state == S_ALLOC) begin
      slot_r <= new_slot;
    end
    if (state == S_ADD) begin
      acc <= add_sum;
    end
    if (fin && out_free) begin
      rsp.new_id      <= fin_id;
      rsp.found_value <= fin_found;
      rsp.status      <= fin_status;
    end
    if (fin && !out_free) begin
      hold_id     <= fin_id;
      hold_found  <= fin_found;
      hold_status <= fin_status;
    end
  end

  // value store: never cleared, a free slot reads as zero through its used bit
  always_ff @(posedge clk) begin
    if (state == S_ALLOC) begin
      value_mem[new_slot] <= val_r;
    end
    if (accept) begin
      v_rd <= value_mem[in_slot];
    end
  end

  // failed allocate and unknown action finish in the transfer cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (accept && !fin) |=> !req.ready)
    else $error("transfer taken while an item is in flight");

  a_group_has_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC) |-> !(&map_word))
    else $error("group marked free but its word is full");

  a_gen_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC) |=> (gen == $past(gen) + GEN_W'(1)))
    else $error("generation not advanced on allocate");

  a_no_all_ones: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIX) |-> (add_sum != '1))
    else $error("all-ones id handed out");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == ST_FULL)) |-> ((rsp.new_id == '0) && (rsp.found_value == '0)))
    else $error("failed allocate carries data");

endmodule
